// File: sv/sscu_pkg.sv
// Shared types, constants and command codes for the sorted cue table.
package sscu_pkg;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned IDX_W        = $clog2(CAPACITY);
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_RETIME = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [CNT_W-1:0] CAPACITY_CNT = CNT_W'(CAPACITY);

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic                    valid;
    logic                    flag;
    logic [TIME_BITS-1:0]    cue_time;
    logic [PAYLOAD_BITS-1:0] cue_payload;
  } cell_t;

  // Operation broadcast to every cell in the execute cycle.
  typedef struct packed {
    logic                    ins_en;
    logic                    ret_en;
    logic [TIME_BITS-1:0]    cue_time;
    logic [PAYLOAD_BITS-1:0] cue_payload;
    logic [IDX_W-1:0]        idx;
    logic [CNT_W-1:0]        fill;
  } op_t;

  // Virtual neighbors at the two ends of the row.
  localparam cell_t EDGE_LEFT  = '{valid: 1'b1, flag: 1'b1, cue_time: '0, cue_payload: '0};
  localparam cell_t EDGE_RIGHT = '{valid: 1'b0, flag: 1'b0, cue_time: '0, cue_payload: '0};

endpackage

// File: sv/sscu_cell.sv
// One table cell: holds an entry, compares it to the broadcast key and shifts.
module sscu_cell (
  input  logic                        clk_i,
  input  logic [sscu_pkg::IDX_W-1:0]  my_idx_i,
  input  sscu_pkg::op_t               op_i,
  input  sscu_pkg::cell_t             left_i,
  input  sscu_pkg::cell_t             right_i,
  output sscu_pkg::cell_t             cell_o,
  output logic                        load_o
);

  logic [sscu_pkg::TIME_BITS-1:0]    time_q, time_d;
  logic [sscu_pkg::PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic valid, flag, take_l, take_r, load;
  logic lo, eq, hi;

  assign valid = {1'b0, my_idx_i} < op_i.fill;
  assign lo    = my_idx_i < op_i.idx;
  assign eq    = my_idx_i == op_i.idx;
  assign hi    = my_idx_i > op_i.idx;

  // Insert asks "at or before the key"; retime orders equal keys by position.
  always_comb begin
    if (op_i.ins_en) begin
      flag = valid && (time_q <= op_i.cue_time);
    end else begin
      flag = valid && ((time_q < op_i.cue_time) ||
                       ((time_q == op_i.cue_time) && lo));
    end
  end

  always_comb begin
    take_l = 1'b0;
    take_r = 1'b0;
    load   = 1'b0;
    if (op_i.ins_en) begin
      if (!flag) begin
        if (left_i.valid && !left_i.flag) begin
          take_l = 1'b1;
        end else if (left_i.valid) begin
          load = 1'b1;
        end
      end
    end else if (op_i.ret_en) begin
      if (lo) begin
        if (!flag) begin
          if (!left_i.flag) take_l = 1'b1;
          else load = 1'b1;
        end
      end else if (eq) begin
        if (!left_i.flag) take_l = 1'b1;
        else if (right_i.flag) take_r = 1'b1;
        else load = 1'b1;
      end else if (hi) begin
        if (flag) begin
          if (right_i.flag) take_r = 1'b1;
          else load = 1'b1;
        end
      end
    end
  end

  always_comb begin
    time_d    = time_q;
    payload_d = payload_q;
    if (load) begin
      time_d    = op_i.cue_time;
      payload_d = op_i.cue_payload;
    end else if (take_l) begin
      time_d    = left_i.cue_time;
      payload_d = left_i.cue_payload;
    end else if (take_r) begin
      time_d    = right_i.cue_time;
      payload_d = right_i.cue_payload;
    end
  end

  // Entry storage is undefined until written, so it carries no reset.
  always_ff @(posedge clk_i) begin
    time_q    <= time_d;
    payload_q <= payload_d;
  end

  assign cell_o = '{valid: valid, flag: flag, cue_time: time_q, cue_payload: payload_q};
  assign load_o = load;

endmodule

// File: sv/stable_sorted_cue_table_unit.sv
// Top level of the stable sorted cue table: command control and the row of cells.
//
// The table holds up to 64 entries (time key and payload) kept in nondecreasing
// time order in a row of identical cells. For each command, start is sampled
// while busy is low; busy is then high for the execute cycle, in which the key
// is broadcast to all cells, each cell compares it with its own entry and the
// whole row shifts by at most one place at the closing clock edge.
// The result item follows in the next cycle with done_o high for exactly that
// one cycle; the receiver cannot stall it, so it must take it then. busy is
// already low during the done_o cycle, so a new item may be started there.
// entry_count_o always shows the number of entries held and is current when
// done_o is high. Insert on a full table, and retime or read at an index at or
// past the count, leave the table unchanged and report the error in status_o.
module stable_sorted_cue_table_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         cmd_i,
  input  logic [sscu_pkg::TIME_BITS-1:0]     cue_time_i,
  input  logic [sscu_pkg::PAYLOAD_BITS-1:0]  cue_payload_i,
  input  logic [sscu_pkg::IDX_W-1:0]         entry_index_i,
  output logic                               done_o,
  output logic [sscu_pkg::CNT_W-1:0]         result_index_o,
  output logic [sscu_pkg::TIME_BITS-1:0]     out_time_o,
  output logic [sscu_pkg::PAYLOAD_BITS-1:0]  out_payload_o,
  output logic [sscu_pkg::CNT_W-1:0]         entry_count_o,
  output logic [1:0]                         status_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [1:0]                        cmd_q;
  logic [sscu_pkg::TIME_BITS-1:0]    time_q;
  logic [sscu_pkg::PAYLOAD_BITS-1:0] payload_q;
  logic [sscu_pkg::IDX_W-1:0]        idx_q;
  logic [sscu_pkg::CNT_W-1:0]        fill_q, fill_d;
  logic [sscu_pkg::CNT_W-1:0]        res_idx_q, res_idx_d;
  logic [sscu_pkg::TIME_BITS-1:0]    res_time_q, res_time_d;
  logic [sscu_pkg::PAYLOAD_BITS-1:0] res_payload_q, res_payload_d;
  logic [1:0]                        status_q, status_d;

  logic accept;
  logic in_range, ins_ok, ret_ok, rd_ok;
  logic [sscu_pkg::TIME_BITS-1:0]    rd_time;
  logic [sscu_pkg::PAYLOAD_BITS-1:0] rd_payload;
  logic [sscu_pkg::IDX_W-1:0]        land_pos;

  sscu_pkg::op_t   op;
  sscu_pkg::cell_t cells [sscu_pkg::CAPACITY];
  logic [sscu_pkg::CAPACITY-1:0] loads;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // Command decode against the current fill count.
  assign in_range = {1'b0, idx_q} < fill_q;
  assign ins_ok   = (cmd_q == sscu_pkg::CMD_INSERT) && (fill_q < sscu_pkg::CAPACITY_CNT);
  assign ret_ok   = (cmd_q == sscu_pkg::CMD_RETIME) && in_range;
  assign rd_ok    = (cmd_q == sscu_pkg::CMD_READ) && in_range;

  // Entry at the requested index: the read data, and the payload a retime carries.
  always_comb begin
    rd_time    = '0;
    rd_payload = '0;
    for (int unsigned j = 0; j < sscu_pkg::CAPACITY; j++) begin
      if (idx_q == sscu_pkg::IDX_W'(j)) begin
        rd_time    = rd_time | cells[j].cue_time;
        rd_payload = rd_payload | cells[j].cue_payload;
      end
    end
  end

  always_comb begin
    op.ins_en      = busy_q && ins_ok;
    op.ret_en      = busy_q && ret_ok;
    op.cue_time    = time_q;
    op.cue_payload = (cmd_q == sscu_pkg::CMD_INSERT) ? payload_q : rd_payload;
    op.idx         = idx_q;
    op.fill        = fill_q;
  end

  for (genvar g = 0; g < sscu_pkg::CAPACITY; g++) begin : g_cell
    sscu_pkg::cell_t left_s, right_s;
    if (g == 0) begin : g_first
      assign left_s = sscu_pkg::EDGE_LEFT;
    end else begin : g_mid_l
      assign left_s = cells[g-1];
    end
    if (g == sscu_pkg::CAPACITY - 1) begin : g_last
      assign right_s = sscu_pkg::EDGE_RIGHT;
    end else begin : g_mid_r
      assign right_s = cells[g+1];
    end
    sscu_cell u_cell (
      .clk_i    (clk_i),
      .my_idx_i (sscu_pkg::IDX_W'(g)),
      .op_i     (op),
      .left_i   (left_s),
      .right_i  (right_s),
      .cell_o   (cells[g]),
      .load_o   (loads[g])
    );
  end

  // On a successful insert or retime exactly one cell loads the new entry; its index is the landing position.
  always_comb begin
    land_pos = '0;
    for (int unsigned j = 0; j < sscu_pkg::CAPACITY; j++) begin
      if (loads[j]) land_pos = land_pos | sscu_pkg::IDX_W'(j);
    end
  end

  always_comb begin
    fill_d        = fill_q + sscu_pkg::CNT_W'(ins_ok);
    res_idx_d     = (ins_ok || ret_ok) ? {1'b0, land_pos} : {1'b0, idx_q};
    res_time_d    = rd_ok ? rd_time : '0;
    res_payload_d = rd_ok ? rd_payload : '0;
    status_d      = sscu_pkg::STATUS_OK;
    case (cmd_q)
      sscu_pkg::CMD_INSERT: begin
        if (!ins_ok) status_d = sscu_pkg::STATUS_FULL;
      end
      sscu_pkg::CMD_RETIME, sscu_pkg::CMD_READ: begin
        if (!in_range) status_d = sscu_pkg::STATUS_RANGE;
      end
      default: status_d = sscu_pkg::STATUS_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      fill_q <= '0;
    end else begin
      done_q <= busy_q;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        busy_q <= 1'b0;
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_i;
      time_q    <= cue_time_i;
      payload_q <= cue_payload_i;
      idx_q     <= entry_index_i;
    end
    if (busy_q) begin
      res_idx_q     <= res_idx_d;
      res_time_q    <= res_time_d;
      res_payload_q <= res_payload_d;
      status_q      <= status_d;
    end
  end

  assign done_o         = done_q;
  assign result_index_o = res_idx_q;
  assign out_time_o     = res_time_q;
  assign out_payload_o  = res_payload_q;
  assign entry_count_o  = fill_q;
  assign status_o       = status_q;

  // An accepted item always enters the execute cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !done_q)
    else $error("accepted item did not enter the execute cycle");

  // Every execute cycle is followed by one result strobe.
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> done_q && !busy_q)
    else $error("execute cycle not followed by a result");

  // The count never exceeds the table size.
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= sscu_pkg::CAPACITY_CNT)
    else $error("entry count beyond capacity");

  // A successful insert or retime has exactly one cell taking the entry.
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (ins_ok || ret_ok)) |-> $onehot(loads))
    else $error("landing position is not unique");

  // The count only grows by one, and only through an insert.
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1))
    else $error("entry count changed by other than one");

endmodule
